// File: hw/rtl/efse_pkg.sv
// shared constants and types of the encoder frame speed estimator
// no dependencies; compiled first
`default_nettype none

package efse_pkg;

	// frame layout
	localparam int HexDigits = 8;
	localparam int PhaseW = $clog2(HexDigits + 2);
	localparam int SplitShift = 4 * (HexDigits / 2);
	localparam logic [15:0] RightMask =
		(SplitShift >= 16) ? 16'hFFFF : 16'((64'd1 << SplitShift) - 64'd1);

	localparam logic [7:0] CharOpen = 8'h5B;
	localparam logic [7:0] CharClose = 8'h5D;

	// request kinds
	localparam logic OpByte = 1'b0;
	localparam logic OpTick = 1'b1;

	// configuration register indexes
	localparam int CfgIndexW = 1;
	localparam logic [CfgIndexW-1:0] CfgSpeedScale = 1'd0;
	localparam logic [CfgIndexW-1:0] CfgAlpha = 1'd1;

	localparam logic [31:0] SpeedScaleReset = 32'd65536;
	localparam logic [15:0] AlphaReset = 16'd4915;
	localparam logic [15:0] AlphaOne = 16'd32768;

	// serial multiplier length, one multiplier bit per cycle
	localparam int MulSteps = 16;
	localparam int MulCntW = $clog2(MulSteps);

	// parser result for the byte being taken this cycle
	typedef struct packed {
		logic done;
		logic bad;
		logic [15:0] left;
		logic [15:0] right;
	} parse_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/efse_if.sv
// channel interfaces: request input, result output and configuration write
// uses efse_pkg for the register index width
`default_nettype none

interface efse_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] rx_byte;

	modport source(output valid, output operation, output rx_byte, input ready);
	modport sink(input valid, input operation, input rx_byte, output ready);
endinterface

interface efse_out_if;
	logic valid;
	logic ready;
	logic [15:0] encoder_left;
	logic [15:0] encoder_right;
	logic signed [31:0] speed_left;
	logic signed [31:0] speed_right;
	logic frame_done;
	logic frame_bad;

	modport source(output valid, output encoder_left, output encoder_right,
		output speed_left, output speed_right, output frame_done, output frame_bad,
		input ready);
	modport sink(input valid, input encoder_left, input encoder_right,
		input speed_left, input speed_right, input frame_done, input frame_bad,
		output ready);
endinterface

interface efse_cfg_if;
	logic valid;
	logic ready;
	logic [efse_pkg::CfgIndexW-1:0] index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/efse_parser.sv
// frame parser: '[' then hex digits then ']', commits left/right counts
// uses efse_pkg for frame constants and the status struct
`default_nettype none

module efse_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire [7:0]           rx_byte,
	output efse_pkg::parse_stat_t stat,
	output logic [15:0]         count_left,
	output logic [15:0]         count_right
);

	logic [efse_pkg::PhaseW-1:0] phase_q, phase_d;
	logic [31:0] acc_q, acc_d;
	logic [4:0]  hv;

	// bit 4 flags a valid digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	always_comb begin
		logic [63:0] wide;
		wide = {32'd0, acc_q};
		hv = hex_value(rx_byte);
		phase_d = phase_q;
		acc_d = acc_q;
		stat.done = 1'b0;
		stat.bad = 1'b0;
		stat.left = count_left;
		stat.right = count_right;
		if (rx_byte == efse_pkg::CharOpen) begin
			stat.bad = (phase_q != '0);
			acc_d = '0;
			phase_d = efse_pkg::PhaseW'(1);
		end else if (phase_q == '0) begin
			// idle, byte ignored
		end else if (phase_q <= efse_pkg::PhaseW'(efse_pkg::HexDigits)) begin
			if (!hv[4]) begin
				stat.bad = 1'b1;
				phase_d = '0;
			end else begin
				acc_d = {acc_q[27:0], hv[3:0]};
				phase_d = phase_q + efse_pkg::PhaseW'(1);
			end
		end else begin
			if (rx_byte == efse_pkg::CharClose) begin
				stat.done = 1'b1;
				stat.right = acc_q[15:0] & efse_pkg::RightMask;
				stat.left = 16'(wide >> efse_pkg::SplitShift);
			end else begin
				stat.bad = 1'b1;
			end
			phase_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			acc_q <= '0;
			count_left <= '0;
			count_right <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			count_left <= stat.left;
			count_right <= stat.right;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/efse_lane.sv
// one side's speed lane: wrapped delta, bit-serial scale multiply with
// saturation, bit-serial ema multiply, rounding; uses efse_pkg
`default_nettype none

module efse_lane (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire [15:0]        count_now,
	input  wire [15:0]        count_before,
	input  wire signed [31:0] speed_old,
	input  wire [31:0]        speed_scale,
	input  wire [15:0]        alpha,
	output logic              done,
	output logic signed [31:0] speed_new
);

	typedef enum logic [2:0] {L_IDLE, L_MUL1, L_SAT, L_MUL2, L_SUM} lstate_t;

	lstate_t state_q;
	logic [efse_pkg::MulCntW-1:0] cnt_q;
	logic        neg_q;
	logic [48:0] p1_q;
	logic [49:0] p2_q;
	logic signed [32:0] diff_q;

	logic signed [17:0] d_wide, d_wrap, d_mag;
	logic [32:0] a1;
	logic [47:0] prod;
	logic signed [31:0] fresh;
	logic signed [32:0] diff;
	logic [33:0] a2;
	logic [50:0] sum;
	logic [15:0] alpha_c;

	always_comb begin
		d_wide = $signed({2'b00, count_now}) - $signed({2'b00, count_before});
		if (d_wide > 18'sd32768) begin
			d_wrap = d_wide - 18'sd65536;
		end else if (d_wide < -18'sd32768) begin
			d_wrap = d_wide + 18'sd65536;
		end else begin
			d_wrap = d_wide;
		end
		d_mag = d_wrap[17] ? -d_wrap : d_wrap;
		alpha_c = (alpha > efse_pkg::AlphaOne) ? efse_pkg::AlphaOne : alpha;

		a1 = p1_q[48:16] + (p1_q[0] ? {1'b0, speed_scale} : 33'd0);

		prod = p1_q[47:0];
		if (!neg_q) begin
			fresh = (prod > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(prod[31:0]);
		end else begin
			fresh = (prod > 48'h8000_0000) ? 32'sh8000_0000 : $signed(~prod[31:0] + 32'd1);
		end
		diff = {fresh[31], fresh} - {speed_old[31], speed_old};

		a2 = p2_q[49:16] + (p2_q[0] ? {diff_q[32], diff_q} : 34'd0);

		// old * 32768 + alpha * (new - old) + half, floor shift by 15
		sum = {p2_q[49], p2_q} + {{4{speed_old[31]}}, speed_old, 15'd0} + 51'd16384;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q <= '0;
			neg_q <= 1'b0;
			p1_q <= '0;
			p2_q <= '0;
			diff_q <= '0;
			done <= 1'b0;
			speed_new <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						neg_q <= d_wrap[17];
						p1_q <= {33'd0, d_mag[15:0]};
						cnt_q <= '0;
						state_q <= L_MUL1;
					end
				end
				L_MUL1: begin
					p1_q <= {a1, p1_q[15:0]} >> 1;
					cnt_q <= cnt_q + efse_pkg::MulCntW'(1);
					if (cnt_q == efse_pkg::MulCntW'(efse_pkg::MulSteps - 1)) begin
						state_q <= L_SAT;
					end
				end
				L_SAT: begin
					diff_q <= diff;
					p2_q <= {34'd0, alpha_c};
					cnt_q <= '0;
					state_q <= L_MUL2;
				end
				L_MUL2: begin
					p2_q <= {a2[33], a2, p2_q[15:1]};
					cnt_q <= cnt_q + efse_pkg::MulCntW'(1);
					if (cnt_q == efse_pkg::MulCntW'(efse_pkg::MulSteps - 1)) begin
						state_q <= L_SUM;
					end
				end
				L_SUM: begin
					speed_new <= $signed(sum[46:15]);
					done <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/encoder_frame_speed_estimator.sv
// Encoder frame parser and speed estimator, top level.
// Requests on item: operation 0 carries a received byte for the frame parser
// ('[' , eight hex digits, ']'), operation 1 is a speed update tick.
// Every request yields exactly one result on result: latest committed counts,
// smoothed Q16.16 speeds and the frame done / bad flags of that byte.
// A byte's result is registered in the cycle it is taken, so it shows in the
// next cycle. A tick runs two bit-serial multiplies per side (one multiplier
// bit a cycle) plus setup, saturate and round steps, then emits its result.
// Throughput: one byte a cycle while result drains; a tick blocks item until
// its work is done and its result has been emitted.
// cfg takes speed_scale (index 0) and smoothing_alpha (index 1) at any time
// and is always ready; it should only be written while the block is idle.
// Reset (arst_n low) clears counts, speeds, parser and loads register resets.
// When result is stalled the output register holds its item and item is not
// ready until that register can be refilled; nothing is dropped.
// Depends on efse_pkg, efse_if, efse_parser and efse_lane.
`default_nettype none

module encoder_frame_speed_estimator (
	input  wire          clk,
	input  wire          arst_n,
	efse_in_if.sink      item,
	efse_out_if.source   result,
	efse_cfg_if.sink     cfg
);

	typedef enum logic [1:0] {T_IDLE, T_RUN, T_EMIT} tstate_t;

	tstate_t state_q;
	logic [31:0] scale_q;
	logic [15:0] alpha_q;
	logic signed [31:0] smooth_l_q, smooth_r_q;
	logic [15:0] prev_l_q, prev_r_q;

	logic out_valid_q;
	logic [15:0] enc_l_q, enc_r_q;
	logic signed [31:0] spd_l_q, spd_r_q;
	logic done_q, bad_q;

	logic out_free, out_load, take, take_byte, take_tick;
	efse_pkg::parse_stat_t pstat;
	logic [15:0] cnt_l, cnt_r;
	logic lane_done_l, lane_done_r;
	logic signed [31:0] new_l, new_r;

	assign out_free = !out_valid_q || result.ready;
	assign item.ready = (state_q == T_IDLE) && out_free;
	assign take = item.valid && item.ready;
	assign take_byte = take && (item.operation == efse_pkg::OpByte);
	assign take_tick = take && (item.operation == efse_pkg::OpTick);
	assign out_load = take_byte || ((state_q == T_EMIT) && out_free);
	assign cfg.ready = 1'b1;

	assign result.valid = out_valid_q;
	assign result.encoder_left = enc_l_q;
	assign result.encoder_right = enc_r_q;
	assign result.speed_left = spd_l_q;
	assign result.speed_right = spd_r_q;
	assign result.frame_done = done_q;
	assign result.frame_bad = bad_q;

	efse_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (take_byte),
		.rx_byte    (item.rx_byte),
		.stat       (pstat),
		.count_left (cnt_l),
		.count_right(cnt_r)
	);

	efse_lane u_lane_l (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (take_tick),
		.count_now   (cnt_l),
		.count_before(prev_l_q),
		.speed_old   (smooth_l_q),
		.speed_scale (scale_q),
		.alpha       (alpha_q),
		.done        (lane_done_l),
		.speed_new   (new_l)
	);

	efse_lane u_lane_r (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (take_tick),
		.count_now   (cnt_r),
		.count_before(prev_r_q),
		.speed_old   (smooth_r_q),
		.speed_scale (scale_q),
		.alpha       (alpha_q),
		.done        (lane_done_r),
		.speed_new   (new_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			scale_q <= efse_pkg::SpeedScaleReset;
			alpha_q <= efse_pkg::AlphaReset;
			smooth_l_q <= '0;
			smooth_r_q <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			out_valid_q <= 1'b0;
			enc_l_q <= '0;
			enc_r_q <= '0;
			spd_l_q <= '0;
			spd_r_q <= '0;
			done_q <= 1'b0;
			bad_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					efse_pkg::CfgSpeedScale: scale_q <= cfg.data;
					efse_pkg::CfgAlpha:      alpha_q <= cfg.data[15:0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				T_IDLE: begin
					if (take_byte) begin
						out_valid_q <= 1'b1;
						enc_l_q <= pstat.left;
						enc_r_q <= pstat.right;
						spd_l_q <= smooth_l_q;
						spd_r_q <= smooth_r_q;
						done_q <= pstat.done;
						bad_q <= pstat.bad;
					end else if (take_tick) begin
						state_q <= T_RUN;
					end
				end
				T_RUN: begin
					// both lanes run in lockstep
					if (lane_done_l && lane_done_r) begin
						smooth_l_q <= new_l;
						smooth_r_q <= new_r;
						prev_l_q <= cnt_l;
						prev_r_q <= cnt_r;
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						enc_l_q <= cnt_l;
						enc_r_q <= cnt_r;
						spd_l_q <= smooth_l_q;
						spd_r_q <= smooth_r_q;
						done_q <= 1'b0;
						bad_q <= 1'b0;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: test/efse_frame_checker.sv
// result checker for the encoder frame speed estimator: watches the request, result and
// register write channels, predicts each result and compares it field by field
// depends on efse_pkg and the channel interfaces in efse_if
`default_nettype none

module efse_frame_checker
	import efse_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	efse_in_if          item,
	efse_out_if         result,
	efse_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [15:0]        enc_left;
		logic [15:0]        enc_right;
		logic signed [31:0] spd_left;
		logic signed [31:0] spd_right;
		logic               done;
		logic               bad;
	} frame_result_t;

	frame_result_t expected_results[$];

	// predicted block state
	logic [31:0]        scale = SpeedScaleReset;
	logic [15:0]        alpha = AlphaReset;
	logic [15:0]        cnt_left = '0;
	logic [15:0]        cnt_right = '0;
	logic [15:0]        prev_left = '0;
	logic [15:0]        prev_right = '0;
	logic signed [31:0] ema_left = '0;
	logic signed [31:0] ema_right = '0;
	int unsigned        frame_phase = 0;
	logic [31:0]        digit_acc = '0;

	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	function automatic logic signed [31:0] smooth_speed(logic [15:0] now, logic [15:0] last,
			logic signed [31:0] old);
		longint delta;
		longint fresh;
		longint weight;
		longint sum;
		delta = longint'(now) - longint'(last);
		if (delta > 32768) delta -= 65536;
		if (delta < -32768) delta += 65536;
		fresh = delta * longint'(scale);
		if (fresh > 64'sd2147483647) fresh = 64'sd2147483647;
		if (fresh < -64'sd2147483648) fresh = -64'sd2147483648;
		weight = (alpha > AlphaOne) ? longint'(AlphaOne) : longint'(alpha);
		sum = weight * fresh + (longint'(AlphaOne) - weight) * longint'(old) + 16384;
		// arithmetic shift gives the floor of the division
		return 32'(sum >>> 15);
	endfunction

	task automatic take_request(logic op, logic [7:0] c);
		frame_result_t r;
		logic [63:0] wide;
		int nib;
		r.done = 1'b0;
		r.bad = 1'b0;
		nib = nibble_of(c);
		if (op == OpTick) begin
			ema_left = smooth_speed(cnt_left, prev_left, ema_left);
			prev_left = cnt_left;
			ema_right = smooth_speed(cnt_right, prev_right, ema_right);
			prev_right = cnt_right;
		end else if (c == CharOpen) begin
			if (frame_phase != 0) r.bad = 1'b1;
			digit_acc = '0;
			frame_phase = 1;
		end else if (frame_phase == 0) begin
			// ignored while waiting for an opening bracket
		end else if (frame_phase <= HexDigits) begin
			if (nib < 0) begin
				r.bad = 1'b1;
				frame_phase = 0;
			end else begin
				digit_acc = {digit_acc[27:0], 4'(nib)};
				frame_phase++;
			end
		end else begin
			if (c == CharClose) begin
				wide = {32'b0, digit_acc};
				cnt_right = wide[15:0] & RightMask;
				cnt_left = 16'(wide >> SplitShift);
				r.done = 1'b1;
			end else begin
				r.bad = 1'b1;
			end
			frame_phase = 0;
		end
		r.enc_left = cnt_left;
		r.enc_right = cnt_right;
		r.spd_left = ema_left;
		r.spd_right = ema_right;
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on %s: got %h, expected %h", field, got, want);
	endtask

	always @(posedge clk) begin
		frame_result_t want;
		if (!arst_n) begin
			mismatches = 0;
			scale = SpeedScaleReset;
			alpha = AlphaReset;
			cnt_left = '0;
			cnt_right = '0;
			prev_left = '0;
			prev_right = '0;
			ema_left = '0;
			ema_right = '0;
			frame_phase = 0;
			digit_acc = '0;
			expected_results.delete();
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request waiting", '0, '0);
				end else begin
					want = expected_results.pop_front();
					if (result.encoder_left !== want.enc_left)
						report_mismatch("encoder_left", 32'(result.encoder_left),
							32'(want.enc_left));
					if (result.encoder_right !== want.enc_right)
						report_mismatch("encoder_right", 32'(result.encoder_right),
							32'(want.enc_right));
					if (result.speed_left !== want.spd_left)
						report_mismatch("speed_left", result.speed_left, want.spd_left);
					if (result.speed_right !== want.spd_right)
						report_mismatch("speed_right", result.speed_right, want.spd_right);
					if (result.frame_done !== want.done)
						report_mismatch("frame_done", 32'(result.frame_done), 32'(want.done));
					if (result.frame_bad !== want.bad)
						report_mismatch("frame_bad", 32'(result.frame_bad), 32'(want.bad));
				end
			end
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				case (cfg.index)
					CfgSpeedScale: begin
						scale = cfg.data;
					end
					CfgAlpha: begin
						alpha = cfg.data[15:0];
					end
					default: begin
					end
				endcase
			end
			if (item.valid === 1'b1 && item.ready === 1'b1)
				take_request(item.operation, item.rx_byte);
		end
		outstanding = expected_results.size();
	end

endmodule

`default_nettype wire

// File: test/encoder_frame_speed_estimator_tb.sv
// top of the encoder frame speed estimator testbench: clock, reset, request and
// register write stimulus, receiver stalls and the verdict
// depends on efse_pkg, efse_if, the block and efse_frame_checker
`default_nettype none

module encoder_frame_speed_estimator_tb;
	import efse_pkg::*;

	localparam int CycleLimit = 300000;
	localparam int PhaseCount = 6;
	localparam int ItemsPerPhase = 250;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycle_count = 0;
	int unsigned mismatches;
	int unsigned outstanding;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	efse_in_if  item_ch();
	efse_out_if result_ch();
	efse_cfg_if cfg_ch();

	encoder_frame_speed_estimator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	efse_frame_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("[encoder_frame_speed_estimator] ERROR");
		$finish;
	end

	always @(negedge clk) result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic bit is_hex_char(logic [7:0] c);
		return c inside {["0":"9"], ["A":"F"], ["a":"f"]};
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10) return "0" + 8'(v);
		return ($urandom_range(1) ? "A" : "a") + 8'(v - 10);
	endfunction

	// any byte that is neither a digit nor a closing bracket
	function automatic logic [7:0] rand_non_hex();
		logic [7:0] c;
		do c = 8'($urandom); while (is_hex_char(c) || c == CharClose);
		return c;
	endfunction

	// called and returning at a falling edge; valid stays high into the next request
	task automatic push_request(logic op, logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.rx_byte <= c;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) push_request(OpByte, s[i]);
	endtask

	task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_frame();
		push_request(OpByte, CharOpen);
		repeat (HexDigits) push_request(OpByte, rand_hex_char());
		push_request(OpByte, CharClose);
	endtask

	// opening bracket, some digits, then a restart, an early close or junk
	task automatic push_broken_frame(output int sent);
		int k;
		logic [7:0] tail;
		k = $urandom_range(HexDigits);
		case ($urandom_range(3))
			0: tail = CharOpen;
			1: tail = (k < HexDigits) ? CharClose : rand_non_hex();
			default: tail = rand_non_hex();
		endcase
		push_request(OpByte, CharOpen);
		repeat (k) push_request(OpByte, rand_hex_char());
		push_request(OpByte, tail);
		sent = k + 2;
	endtask

	task automatic run_directed();
		push_request(OpTick, 8'hFF);
		// ignored while idle
		push_request(OpByte, 8'hFF);
		// restart mid frame, then a frame at the wrap boundary
		push_text("[1[8000fA09]");
		push_request(OpTick, 8'h00);
		// early close, then a full frame with no closing bracket
		push_text("[][7fa08A0F");
		push_request(OpByte, 8'h00);
	endtask

	initial begin
		int n;
		int sent;
		int pick;
		logic [31:0] scale_val;
		logic [15:0] alpha_val;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OpByte;
		item_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CfgSpeedScale;
		cfg_ch.data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int p = 0; p < PhaseCount; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (p)
				0: begin
					scale_val = SpeedScaleReset;
					alpha_val = AlphaReset;
				end
				1: begin
					scale_val = 32'hFFFF_FFFF;
					alpha_val = AlphaOne;
				end
				2: begin
					scale_val = '0;
					alpha_val = '0;
				end
				3: begin
					scale_val = $urandom;
					alpha_val = 16'hFFFF;
				end
				4: begin
					scale_val = $urandom_range(1, 1 << 20);
					alpha_val = 16'($urandom_range(AlphaOne));
				end
				default: begin
					scale_val = $urandom_range(1, 4000);
					alpha_val = 16'($urandom_range(AlphaOne));
				end
			endcase
			write_reg(CfgSpeedScale, scale_val);
			write_reg(CfgAlpha, {16'b0, alpha_val});
			if (p == 0) run_directed();

			n = 0;
			while (n < ItemsPerPhase) begin
				pick = $urandom_range(99);
				if (pick < 50) begin
					push_frame();
					n += HexDigits + 2;
				end else if (pick < 75) begin
					push_request(OpTick, 8'($urandom));
					n++;
				end else if (pick < 88) begin
					push_broken_frame(sent);
					n += sent;
				end else begin
					// line noise between frames, mostly ignored
					push_request(OpByte, 8'($urandom));
					n++;
				end
			end
			wait_idle();
		end

		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("[encoder_frame_speed_estimator] OK");
		else
			$display("[encoder_frame_speed_estimator] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: encoder_frame_speed_estimator.f
hw/rtl/efse_pkg.sv
hw/rtl/efse_if.sv
hw/rtl/efse_parser.sv
hw/rtl/efse_lane.sv
hw/rtl/encoder_frame_speed_estimator.sv
test/efse_frame_checker.sv
test/encoder_frame_speed_estimator_tb.sv
